// ===== hdl/rdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

	localparam int unsigned INT_W       = 16;
	localparam int unsigned FRAC_W      = 32;
	localparam int unsigned BASE_W      = 5;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned MAX_RESULTS = 31;
	localparam int unsigned INT_DIGITS  = 16;
	localparam int unsigned DEPTH_W     = 5;
	localparam int unsigned TOT_W       = 5;
	localparam int unsigned DIV_BITS    = 8;

	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
	localparam logic [BASE_W-1:0] BASE_RESET = 5'd2;

	typedef struct packed {
		logic [INT_W-1:0]  int_value;
		logic [FRAC_W-1:0] frac_value;
	} req_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               is_fraction;
		logic               last;
	} rsp_t;

	// one queued conversion: operands, effective base and class
	typedef struct packed {
		logic [INT_W-1:0]  int_value;
		logic [FRAC_W-1:0] frac_value;
		logic [BASE_W-1:0] base;
		logic              is_zero;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_INT,
		ST_FRAC
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/rdc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdc_front
	import rdc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire req_t              req,
	input  wire logic              cfg_we,
	input  wire logic [BASE_W-1:0] cfg_data,
	output logic                   job_valid,
	output job_t                   job,
	input  wire logic              job_pop
);

	logic [BASE_W-1:0] base_reg_q;
	logic [BASE_W-1:0] base_eff;
	job_t              entry;
	job_t              slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_reg_q <= cfg_data;
		end
	end

	// saturate the radix into 2..16
	always_comb begin
		if (base_reg_q < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (base_reg_q > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = base_reg_q;
		end
	end

	always_comb begin
		entry.int_value  = req.int_value;
		entry.frac_value = req.frac_value;
		entry.base       = base_eff;
		entry.is_zero    = (req.int_value == '0) && (req.frac_value == '0);
	end

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_pop && job_valid;
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rdc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdc_back
	import rdc_pkg::*;
#(
	parameter int unsigned FRAC_DIGITS = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire job_t job,
	output logic      job_pop,
	output logic      result_valid,
	output rsp_t      result
);

	localparam int unsigned FC_W = $clog2(FRAC_DIGITS + 1);
	localparam int unsigned P_W  = FRAC_W + BASE_W;

	state_t               state_q;
	state_t               state_d;
	logic [INT_W-1:0]     quo_q;
	logic [BASE_W-1:0]    rem_q;
	logic                 step_q;
	logic [DIGIT_W-1:0]   stack_q [INT_DIGITS];
	logic [DEPTH_W-1:0]   depth_q;
	logic [FRAC_W-1:0]    frac_q;
	logic [BASE_W-1:0]    base_q;
	logic [FC_W-1:0]      fcnt_q;
	logic [TOT_W-1:0]     tot_q;
	logic                 result_valid_q;
	rsp_t                 result_q;

	logic [BASE_W-1:0]    div_rem;
	logic [DIV_BITS-1:0]  div_qbits;
	logic [INT_W-1:0]     div_quo;
	logic [P_W-1:0]       prod;
	logic [DEPTH_W-1:0]   top_idx;

	logic                 emit;
	rsp_t                 emit_rsp;
	logic                 take;

	// eight restoring-division steps per cycle over the top byte of the dividend
	always_comb begin
		logic [BASE_W:0] r6;
		logic [BASE_W-1:0] r;
		r = rem_q;
		div_qbits = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			r6 = {r, quo_q[INT_W-1-i]};
			if (r6 >= {1'b0, base_q}) begin
				r6 = r6 - {1'b0, base_q};
				div_qbits[DIV_BITS-1-i] = 1'b1;
			end
			r = r6[BASE_W-1:0];
		end
		div_rem = r;
		div_quo = {quo_q[INT_W-DIV_BITS-1:0], div_qbits};
	end

	assign prod    = {{BASE_W{1'b0}}, frac_q} * {{FRAC_W{1'b0}}, base_q};
	assign top_idx = depth_q - DEPTH_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid && !job.is_zero) begin
					if (job.int_value != '0) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_FRAC;
					end
				end
			end
			ST_DIV: begin
				if (step_q && (div_quo == '0)) begin
					state_d = ST_INT;
				end
			end
			ST_INT: begin
				if (depth_q == DEPTH_W'(1)) begin
					state_d = (frac_q != '0) ? ST_FRAC : ST_IDLE;
				end
			end
			ST_FRAC: begin
				if (emit_rsp.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		job_pop  = 1'b0;
		take     = 1'b0;
		emit     = 1'b0;
		emit_rsp = '0;
		case (state_q)
			ST_IDLE: begin
				job_pop = job_valid;
				take    = job_valid;
				if (job_valid && job.is_zero) begin
					emit          = 1'b1;
					emit_rsp.last = 1'b1;
				end
			end
			ST_DIV: begin
			end
			ST_INT: begin
				emit           = 1'b1;
				emit_rsp.digit = stack_q[top_idx[DEPTH_W-2:0]];
				emit_rsp.last  = (depth_q == DEPTH_W'(1)) && (frac_q == '0);
			end
			ST_FRAC: begin
				emit                 = 1'b1;
				emit_rsp.digit       = prod[FRAC_W+DIGIT_W-1:FRAC_W];
				emit_rsp.is_fraction = 1'b1;
				emit_rsp.last        = (prod[FRAC_W-1:0] == '0)
					|| (fcnt_q == FC_W'(FRAC_DIGITS - 1))
					|| (tot_q == TOT_W'(MAX_RESULTS - 1));
			end
			default: begin
			end
		endcase
	end

	// operand and digit registers
	always_ff @(posedge clk) begin
		if (take) begin
			quo_q  <= job.int_value;
			frac_q <= job.frac_value;
			base_q <= job.base;
		end else if (state_q == ST_DIV) begin
			quo_q <= div_quo;
			if (step_q) begin
				stack_q[depth_q[DEPTH_W-2:0]] <= div_rem[DIGIT_W-1:0];
			end
		end else if (state_q == ST_FRAC) begin
			frac_q <= prod[FRAC_W-1:0];
		end
		if (emit) begin
			result_q <= emit_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rem_q          <= '0;
			step_q         <= 1'b0;
			depth_q        <= '0;
			fcnt_q         <= '0;
			tot_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit;
			if (take) begin
				rem_q   <= '0;
				step_q  <= 1'b0;
				depth_q <= '0;
				fcnt_q  <= '0;
				tot_q   <= '0;
			end else begin
				case (state_q)
					ST_DIV: begin
						step_q <= !step_q;
						if (step_q) begin
							rem_q   <= '0;
							depth_q <= depth_q + DEPTH_W'(1);
						end else begin
							rem_q <= div_rem;
						end
					end
					ST_INT: begin
						depth_q <= depth_q - DEPTH_W'(1);
						tot_q   <= tot_q + TOT_W'(1);
					end
					ST_FRAC: begin
						fcnt_q <= fcnt_q + FC_W'(1);
						tot_q  <= tot_q + TOT_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_digit_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> ({1'b0, result_q.digit} < base_q))
		else $error("digit not below base");

	a_int_stack_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INT) |-> (depth_q != '0))
		else $error("integer digit popped from empty stack");

	a_frac_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.is_fraction && !result_q.last)
		|=> (result_valid_q && result_q.is_fraction))
		else $error("fraction digit run broken");

	a_frac_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FC_W'(FRAC_DIGITS))
		else $error("fraction digit count beyond limit");
`endif

endmodule

`default_nettype wire

// ===== hdl/radix_digit_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload            Direction
// request   start / busy            req (req_t)        in
// result    result_valid (strobe)   result (rsp_t)     out
// config    cfg_we                  cfg_data (5 bit)   in
//
// A request is taken when start is high and busy is low; it is queued (two
// deep) with the saturated base, so busy only rises when the queue is full.
// Per request: the job is dequeued; each integer digit comes out of the
// byte-wise divider onto the digit stack and is then emitted from it, and
// each fraction digit comes from one 32x5 multiply.
// Reset clears the queue, the sequencer and sets base to 2.
// Results are strobed for exactly one cycle; the receiver cannot stall them.

module radix_digit_converter
	import rdc_pkg::*;
#(
	parameter int unsigned FRAC_DIGITS = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire req_t              req,
	input  wire logic              cfg_we,
	input  wire logic [BASE_W-1:0] cfg_data,
	output logic                   result_valid,
	output rsp_t                   result
);

	logic job_valid;
	job_t job;
	logic job_pop;

	// front: hold the base register, classify and queue requests
	rdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// back: divide out integer digits, reverse them, then multiply out the fraction
	rdc_back #(
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== test/radix_digit_converter_tb.sv =====
`timescale 1ns / 1ps

module radix_digit_converter_tb;
	import rdc_pkg::*;

	localparam int unsigned FRAC_DIGITS = 15;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned DIRECTED_N  = 24;
	localparam int unsigned RAND_PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 31;
	localparam int unsigned TAIL_CYCLES = 100;

	// One directed request. A nonzero known_count lists the digits by hand:
	// known_digits reads like the number itself (first digit in the highest
	// used nibble), and digits from index frac_start on are fractional.
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [INT_W-1:0]  int_value;
		logic [FRAC_W-1:0] frac_value;
		logic [3:0]        known_count;
		logic [3:0]        frac_start;
		logic [31:0]       known_digits;
	} vector_t;

	localparam vector_t DIRECTED [DIRECTED_N] = '{
		// base 2, the reset value
		'{5'd2,  16'h0000, 32'h0000_0000, 4'd1, 4'd1, 32'h0},        // zero input
		'{5'd2,  16'h0001, 32'h0000_0000, 4'd1, 4'd1, 32'h1},
		'{5'd2,  16'h0000, 32'h8000_0000, 4'd1, 4'd0, 32'h1},        // fraction only
		'{5'd2,  16'hFFFF, 32'h0000_0000, 4'd0, 4'd0, 32'h0},
		'{5'd2,  16'hFFFF, 32'hFFFF_FFFF, 4'd0, 4'd0, 32'h0},        // most digits
		'{5'd2,  16'h0000, 32'h0000_0001, 4'd0, 4'd0, 32'h0},        // cut by digit cap
		'{5'd2,  16'h8000, 32'h0000_0001, 4'd0, 4'd0, 32'h0},
		// base 16
		'{5'd16, 16'hFFFF, 32'h0000_0000, 4'd4, 4'd4, 32'hFFFF},
		'{5'd16, 16'h00AB, 32'h8000_0000, 4'd3, 4'd2, 32'hAB8},
		'{5'd16, 16'h0000, 32'hFFFF_FFFF, 4'd8, 4'd0, 32'hFFFF_FFFF},
		'{5'd16, 16'h1234, 32'h5678_0000, 4'd8, 4'd4, 32'h1234_5678},
		// base 10
		'{5'd10, 16'd1234, 32'h0000_0000, 4'd4, 4'd4, 32'h1234},
		'{5'd10, 16'd65535, 32'h0000_0000, 4'd5, 4'd5, 32'h65535},
		'{5'd10, 16'h0000, 32'h4000_0000, 4'd2, 4'd0, 32'h25},
		'{5'd10, 16'd7,    32'h8000_0000, 4'd2, 4'd1, 32'h75},
		// odd bases and out-of-range register values
		'{5'd3,  16'hFFFF, 32'h5555_5555, 4'd0, 4'd0, 32'h0},
		'{5'd0,  16'd5,    32'h0000_0000, 4'd3, 4'd3, 32'h101},       // acts as 2
		'{5'd1,  16'h0000, 32'hC000_0000, 4'd2, 4'd0, 32'h11},        // acts as 2
		'{5'd17, 16'h00FF, 32'h0000_0000, 4'd2, 4'd2, 32'hFF},        // acts as 16
		'{5'd31, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 4'd0, 32'h0},         // acts as 16
		'{5'd7,  16'd48,   32'h0000_0000, 4'd2, 4'd2, 32'h66},
		'{5'd5,  16'h0000, 32'h3333_3333, 4'd0, 4'd0, 32'h0},
		'{5'd9,  16'd100,  32'h1234_5678, 4'd0, 4'd0, 32'h0},
		'{5'd16, 16'h0000, 32'h0000_0000, 4'd1, 4'd1, 32'h0}         // zero at base 16
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              req = '0;
	logic              cfg_we = 1'b0;
	logic [BASE_W-1:0] cfg_data = '0;
	logic              result_valid;
	rsp_t              result;

	// digits still owed by the block, oldest first
	rsp_t              pending_digits[$];
	rsp_t              next_digit;
	logic [BASE_W-1:0] base_setting = BASE_RESET;
	int unsigned       mismatch_count = 0;
	int unsigned       cycle_count = 0;

	radix_digit_converter #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the digits of one request at the given base register value
	// and append them to the pending store. Integer digits come off a stack
	// filled by repeated division; fraction digits come from the top bits of
	// remainder * base, the low 32 bits carrying on as the new remainder.
	function automatic void convert_to_digits(req_t r, logic [BASE_W-1:0] base_reg);
		int unsigned       radix;
		logic [INT_W-1:0]  quotient;
		logic [FRAC_W-1:0] remainder;
		logic [36:0]       product;
		logic [3:0]        int_stack[INT_DIGITS];
		int                depth;
		int                count;
		int                k;
		rsp_t              held;
		rsp_t              fresh;
		logic              have_held;

		if (base_reg < BASE_MIN)
			radix = BASE_MIN;
		else if (base_reg > BASE_MAX)
			radix = BASE_MAX;
		else
			radix = base_reg;

		if (r.int_value == '0 && r.frac_value == '0) begin
			fresh.digit = '0;
			fresh.is_fraction = 1'b0;
			fresh.last = 1'b1;
			pending_digits.push_back(fresh);
			return;
		end

		quotient = r.int_value;
		remainder = r.frac_value;
		depth = 0;
		count = 0;
		have_held = 1'b0;
		held = '0;

		while (quotient != '0 && depth < INT_DIGITS) begin
			int_stack[depth] = 4'(quotient % radix);
			quotient = INT_W'(quotient / radix);
			depth++;
		end

		// hold one digit back so the final one can carry the last flag
		for (k = depth - 1; k >= 0; k--) begin
			if (have_held)
				pending_digits.push_back(held);
			held.digit = int_stack[k];
			held.is_fraction = 1'b0;
			held.last = 1'b0;
			have_held = 1'b1;
			count++;
		end

		for (k = 0; k < FRAC_DIGITS && remainder != '0 && count < MAX_RESULTS; k++) begin
			product = 37'(remainder) * 37'(radix);
			if (have_held)
				pending_digits.push_back(held);
			held.digit = product[35:32];
			held.is_fraction = 1'b1;
			held.last = 1'b0;
			have_held = 1'b1;
			remainder = product[31:0];
			count++;
		end

		held.last = 1'b1;
		pending_digits.push_back(held);
	endfunction

	// Append the hand-written digits of a directed row.
	function automatic void queue_listed_digits(vector_t row);
		int         k;
		int         total;
		logic [31:0] shifted;
		rsp_t       entry;

		total = int'(row.known_count);
		for (k = 0; k < total; k++) begin
			shifted = row.known_digits >> (4 * (total - 1 - k));
			entry.digit = shifted[3:0];
			entry.is_fraction = (k >= int'(row.frac_start));
			entry.last = (k == total - 1);
			pending_digits.push_back(entry);
		end
	endfunction

	// Random request: favor zero parts, short fractions that end early, all
	// ones and small integers, so the ends of every path come up often.
	function automatic req_t random_request();
		req_t r;

		case ($urandom_range(0, 9))
			0, 1:    r.int_value = '0;
			2, 3:    r.int_value = INT_W'($urandom_range(1, 255));
			4:       r.int_value = '1;
			default: r.int_value = INT_W'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1:    r.frac_value = '0;
			2, 3:    r.frac_value = $urandom & (32'hFFFF_FFFF << $urandom_range(4, 31));
			4:       r.frac_value = '1;
			default: r.frac_value = $urandom;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Raise start with the request and hold it until an edge where busy is
	// low; return in the time step of that edge.
	task automatic send_request(req_t r);
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_sender(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and wait until every owed digit has come out.
	task automatic drain_digits();
		start <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_base(logic [BASE_W-1:0] value);
		drain_digits();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_setting = value;
	endtask

	// Check each strobed digit against the oldest owed one. Outputs are read
	// at the edge that ends their cycle, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_digits.size() == 0) begin
				report_mismatch("digit with no request owing one", result.digit, 0);
			end else begin
				next_digit = pending_digits.pop_front();
				if (result.digit !== next_digit.digit)
					report_mismatch("digit value", result.digit, next_digit.digit);
				if (result.is_fraction !== next_digit.is_fraction)
					report_mismatch("fraction flag", result.is_fraction,
						next_digit.is_fraction);
				if (result.last !== next_digit.last)
					report_mismatch("last flag", result.last, next_digit.last);
			end
		end
	end

	// Bound the run in case the block hangs or stops taking requests.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL radix_digit_converter");
			$finish;
		end
	end

	initial begin
		int      i;
		int      k;
		int      phase;
		logic    gaps_on;
		req_t    r;
		vector_t row;

		// hold reset low at the start, then release it on an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: change the base only between rows, with the block
		// drained, and use the listed digits where a row has them.
		for (i = 0; i < DIRECTED_N; i++) begin
			row = DIRECTED[i];
			if (row.base != base_setting)
				write_base(row.base);
			r.int_value = row.int_value;
			r.frac_value = row.frac_value;
			send_request(r);
			if (row.known_count != '0)
				queue_listed_digits(row);
			else
				convert_to_digits(r, base_setting);
		end

		// Random phases, each at a fresh base; mostly legal radixes, now and
		// then a raw register value that the block must clamp.
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if ($urandom_range(0, 3) == 0)
				write_base(BASE_W'($urandom_range(0, 31)));
			else
				write_base(BASE_W'($urandom_range(2, 16)));
			// keep the final phase free of gaps; others may go without too
			gaps_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// let the block run dry once in the middle of a phase
				if (phase == 2 && k == PHASE_ITEMS / 2)
					drain_digits();
				r = random_request();
				send_request(r);
				convert_to_digits(r, base_setting);
				if (gaps_on && $urandom_range(0, 3) == 0)
					idle_sender($urandom_range(1, 7));
			end
		end

		// drain, then watch a while longer for stray digits
		drain_digits();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS radix_digit_converter");
		else
			$display("FAIL radix_digit_converter");
		$finish;
	end

endmodule
